[src/encoder_bank_accumulator_defines.svh]
// Assertion macros for the encoder bank accumulator.
`ifndef ENCODER_BANK_ACCUMULATOR_DEFINES_SVH
`define ENCODER_BANK_ACCUMULATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Condition holds in the same cycle as the trigger.
`define EBA_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("eba check failed");
// Condition holds in the cycle after the trigger.
`define EBA_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("eba check failed");
`else
`define EBA_ASSERT_NOW(label, trig, cond)
`define EBA_ASSERT_NEXT(label, trig, cond)
`endif
`endif

[src/eba_pkg.sv]
// Shared types and constants of the encoder bank accumulator.
`default_nettype none
package eba_pkg;

  localparam int MAX_ENCODERS     = 8;
  localparam int NUM_ENCODERS_DEF = 4;
  localparam int COUNT_W          = 8;
  localparam int BANK_W           = 2;
  localparam int BANKS            = 4;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd64;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = -8'sd64;

  // Item operation codes; code 3 is unused: it changes no counter and returns a zero result.
  typedef enum logic [1:0] {
    ACT_POLL  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // Command broadcast to every lane.
  typedef struct packed {
    logic accept;
    logic poll;
    logic clear;
    logic shift;
  } lane_cmd_t;

endpackage
`default_nettype wire

[src/eba_lane.sv]
// One encoder lane: step detection and four saturating bank counters.
`default_nettype none
module eba_lane
  import eba_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lane_cmd_t                 cmd,
  input  wire logic [1:0]                enc_bits,
  input  wire logic                      button,
  input  wire logic [BANK_W-1:0]         read_bank,
  output logic                           moved,
  output logic signed [COUNT_W-1:0]      rd_count
);

  logic                       prev_b;
  logic signed [COUNT_W-1:0]  cnt [BANKS];
  logic [BANK_W-1:0]          bank;
  logic                       step;
  logic                       up;

  // Bank order: normal, shift, button, button with shift
  assign bank  = {button, cmd.shift};
  assign step  = enc_bits[1] ^ prev_b;
  assign up    = (enc_bits[0] == enc_bits[1]);
  assign moved = cmd.poll & step;

  // Previous phase bit, kept across clears
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_b <= 1'b0;
    end else if (cmd.accept && cmd.poll) begin
      prev_b <= enc_bits[1];
    end
  end

  // Bank counters
  for (genvar k = 0; k < BANKS; k++) begin : g_bank
    always_ff @(posedge clk) begin
      if (rst) begin
        cnt[k] <= '0;
      end else if (cmd.accept) begin
        if (cmd.clear) begin
          cnt[k] <= '0;
        end else if (moved && bank == BANK_W'(k)) begin
          if (up) begin
            if (cnt[k] < COUNT_MAX) cnt[k] <= cnt[k] + 8'sd1;
          end else begin
            if (cnt[k] > COUNT_MIN) cnt[k] <= cnt[k] - 8'sd1;
          end
        end
      end
    end
  end

  // Read select
  always_comb begin
    unique case (read_bank)
      2'd0:    rd_count = cnt[0];
      2'd1:    rd_count = cnt[1];
      2'd2:    rd_count = cnt[2];
      default: rd_count = cnt[3];
    endcase
  end

endmodule
`default_nettype wire

[src/eba_merge.sv]
// Merge stage: combines lane results into the registered output.
`default_nettype none
module eba_merge
  import eba_pkg::*;
#(
  parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    action,
  input  wire logic [2:0]                    read_encoder,
  input  wire logic signed [COUNT_W-1:0]     lane_count [NUM_ENCODERS],
  input  wire logic [NUM_ENCODERS-1:0]       lane_moved,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COUNT_W-1:0]          count_value,
  output logic [MAX_ENCODERS-1:0]            moved_mask
);

  logic signed [COUNT_W-1:0]  sel_count;
  logic [MAX_ENCODERS-1:0]    mask_next;
  logic                       accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Pick the read counter; missing encoders read as zero
  always_comb begin
    sel_count = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      if (action == ACT_READ && read_encoder == 3'(i)) sel_count = lane_count[i];
    end
  end

  // Moved mask, upper encoders never step
  always_comb begin
    mask_next = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      mask_next[i] = lane_moved[i];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count_value <= sel_count;
      moved_mask  <= mask_next;
    end
  end

endmodule
`default_nettype wire

[src/encoder_bank_accumulator.sv]
// Encoder bank accumulator: input channel, lane bank, merge stage.
//
// Usage:
//   Input channel in_valid/in_ready carries one item: a poll (action 0), a read
//   of one counter (action 1) or a clear of all counters (action 2).
//   Output channel out_valid/out_ready carries exactly one result per item:
//   count_value (read value, else zero) and moved_mask (encoders that stepped).
//   The result is registered and appears in the cycle after the input transfer.
//   Throughput: one item per cycle unless stalled; one lane per encoder updates
//   its four counters in parallel, and the single output register sets the rate.
//   A new item is taken while the held result is being taken in the same cycle.
//   When the receiver stalls, the result is held and in_ready drops until it
//   is taken; no item is lost.
//   Reset clears all counters, the stored phase bits and the output valid
//   flag; the block is ready in the cycle after reset.
`default_nettype none
`include "encoder_bank_accumulator_defines.svh"
module encoder_bank_accumulator
  import eba_pkg::*;
#(
  parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  action,
  input  wire logic [2*MAX_ENCODERS-1:0]   encoder_bits,
  input  wire logic [MAX_ENCODERS-1:0]     button_held_mask,
  input  wire logic                        shift_held,
  input  wire logic [2:0]                  read_encoder,
  input  wire logic [BANK_W-1:0]           read_bank,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [COUNT_W-1:0]        count_value,
  output logic [MAX_ENCODERS-1:0]          moved_mask
);

  lane_cmd_t                  cmd;
  logic signed [COUNT_W-1:0]  lane_count [NUM_ENCODERS];
  logic [NUM_ENCODERS-1:0]    lane_moved;

  // Command broadcast
  assign cmd.accept = in_valid && in_ready;
  assign cmd.poll   = (action == ACT_POLL);
  assign cmd.clear  = (action == ACT_CLEAR);
  assign cmd.shift  = shift_held;

  // Encoder lanes
  for (genvar i = 0; i < NUM_ENCODERS; i++) begin : g_lane
    eba_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .enc_bits  (encoder_bits[2*i +: 2]),
      .button    (button_held_mask[i]),
      .read_bank (read_bank),
      .moved     (lane_moved[i]),
      .rd_count  (lane_count[i])
    );
  end

  // Merge and output register
  eba_merge #(
    .NUM_ENCODERS (NUM_ENCODERS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .read_encoder (read_encoder),
    .lane_count   (lane_count),
    .lane_moved   (lane_moved),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .count_value  (count_value),
    .moved_mask   (moved_mask)
  );

  // Checks
  `EBA_ASSERT_NEXT(a_transfer_gives_result, in_valid && in_ready, out_valid)
  `EBA_ASSERT_NOW(a_stall_only_when_full, !in_ready, out_valid)
  `EBA_ASSERT_NOW(a_poll_has_no_count, out_valid && moved_mask != '0, count_value == '0)
  `EBA_ASSERT_NEXT(a_read_has_no_moves, in_valid && in_ready && action == ACT_READ, moved_mask == '0)
  `EBA_ASSERT_NOW(a_count_in_range, out_valid, count_value >= COUNT_MIN && count_value <= COUNT_MAX)

endmodule
`default_nettype wire

[bench/encoder_bank_accumulator_tb.sv]
// Self-checking testbench for the encoder bank accumulator.
`timescale 1ns / 1ps
module encoder_bank_accumulator_tb;
  import eba_pkg::*;

  localparam int ENC = NUM_ENCODERS_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1550;
  localparam int CALM_ITEMS = 150;
  localparam int REPORT_LIMIT = 10;

  // Direction bias of one encoder during a run of polls
  typedef enum int {DIR_UP, DIR_DOWN, DIR_MIXED} turn_t;

  // One result as the block should return it
  typedef struct packed {
    logic signed [COUNT_W-1:0] value;
    logic [MAX_ENCODERS-1:0]   moved;
  } reply_t;

  // Tracks counter state and the queue of results still owed by the block
  class encoder_count_board;
    logic [2*MAX_ENCODERS-1:0] last_bits;
    logic signed [COUNT_W-1:0] counts [ENC][BANKS];
    reply_t                    pending_replies[$];
    int                        errors;

    function new();
      last_bits = '0;
      errors = 0;
      wipe_counts();
    endfunction

    function void wipe_counts();
      foreach (counts[e, k]) counts[e][k] = '0;
    endfunction

    // Note an accepted input transfer and queue the result it should give
    function void log_item(input logic [1:0] act, input logic [2*MAX_ENCODERS-1:0] bits,
                           input logic [MAX_ENCODERS-1:0] btn, input logic shf,
                           input logic [2:0] renc, input logic [BANK_W-1:0] rbank);
      reply_t            r;
      logic [BANK_W-1:0] bank;
      r = '0;
      case (act)
        ACT_POLL: begin
          for (int i = 0; i < ENC; i++) begin
            // a step is a change of the encoder's upper phase bit
            if (bits[2*i+1] != last_bits[2*i+1]) begin
              bank = {btn[i], shf};
              if (bits[2*i] == bits[2*i+1]) begin
                if (counts[i][bank] < COUNT_MAX) counts[i][bank] = counts[i][bank] + 8'sd1;
              end else if (counts[i][bank] > COUNT_MIN) begin
                counts[i][bank] = counts[i][bank] - 8'sd1;
              end
              r.moved[i] = 1'b1;
            end
          end
          // upper encoders are remembered even though they are never counted
          last_bits = bits;
        end
        ACT_READ: begin
          if (renc < ENC) r.value = counts[renc][rbank];
        end
        ACT_CLEAR: wipe_counts();
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    // Compare a result transfer with the oldest queued expectation
    function void check_reply(input logic signed [COUNT_W-1:0] value,
                              input logic [MAX_ENCODERS-1:0] moved);
      reply_t exp_r;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result count_value %0d moved_mask %02h",
                   $time, value, moved);
        return;
      end
      exp_r = pending_replies.pop_front();
      if (value !== exp_r.value || moved !== exp_r.moved) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: mismatch count_value exp %0d got %0d, moved_mask exp %02h got %02h",
                   $time, $signed(exp_r.value), value, exp_r.moved, moved);
      end
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    // Anything still owed at the end counts against the run
    function void close_out();
      if (pending_replies.size() != 0) begin
        errors += pending_replies.size();
        $display("%0d results never arrived", pending_replies.size());
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      action = ACT_POLL;
  logic [2*MAX_ENCODERS-1:0]       encoder_bits = '0;
  logic [MAX_ENCODERS-1:0]         button_held_mask = '0;
  logic                            shift_held = 1'b0;
  logic [2:0]                      read_encoder = '0;
  logic [BANK_W-1:0]               read_bank = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic signed [COUNT_W-1:0]       count_value;
  logic [MAX_ENCODERS-1:0]         moved_mask;

  encoder_count_board board = new();

  // stimulus state
  logic [2*MAX_ENCODERS-1:0] gen_bits = '0;
  turn_t                     run_dir [MAX_ENCODERS];
  int                        step_pct = 50;
  int                        gap_pct = 20;
  int                        stall_pct = 20;
  int                        sent = 0;
  bit                        calm = 1'b0;

  encoder_bank_accumulator #(
    .NUM_ENCODERS(ENC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .encoder_bits(encoder_bits),
    .button_held_mask(button_held_mask),
    .shift_held(shift_held),
    .read_encoder(read_encoder),
    .read_bank(read_bank),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .count_value(count_value),
    .moved_mask(moved_mask)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels mid-cycle, clear of the edge that moves them
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        board.log_item(action, encoder_bits, button_held_mask, shift_held,
                       read_encoder, read_bank);
      if (out_valid && out_ready) board.check_reply(count_value, moved_mask);
    end
  end

  // Receiver: random stall bursts, none once the run goes calm
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Offer one item, hold it until the transfer, then maybe idle a while
  task automatic send_item(input logic [1:0] act, input logic [2*MAX_ENCODERS-1:0] bits,
                           input logic [MAX_ENCODERS-1:0] btn, input logic shf,
                           input logic [2:0] renc, input logic [BANK_W-1:0] rbank);
    in_valid         <= 1'b1;
    action           <= act;
    encoder_bits     <= bits;
    button_held_mask <= btn;
    shift_held       <= shf;
    read_encoder     <= renc;
    read_bank        <= rbank;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (act == ACT_POLL) gen_bits = bits;
    sent++;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Hold the input side off until every owed result has been taken
  task automatic wait_drained();
    if (board.outstanding() != 0) begin
      in_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clk);
    end
  endtask

  // Next poll pattern: quadrature steps following the run's direction bias
  function automatic logic [2*MAX_ENCODERS-1:0] stepped_bits();
    logic [2*MAX_ENCODERS-1:0] b;
    b = gen_bits;
    for (int i = 0; i < MAX_ENCODERS; i++) begin
      if ($urandom_range(0, 99) < step_pct) b[2*i+1] = ~gen_bits[2*i+1];
      case (run_dir[i])
        DIR_UP:   b[2*i] = b[2*i+1];
        DIR_DOWN: b[2*i] = ~b[2*i+1];
        default:  b[2*i] = 1'($urandom_range(0, 1));
      endcase
    end
    return b;
  endfunction

  initial begin
    int                      pick;
    int                      run_len;
    bit                      paused;
    logic [MAX_ENCODERS-1:0] run_btn;
    logic                    run_shift;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one step in each bank, stored upper encoders, missing reads,
    // unused action, clear keeping the phase bits
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0, 3'd0, 2'd0);
    send_item(ACT_POLL,   16'hFFFF, 8'h00, 1'b0, 3'd0, 2'd0);
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0, 3'd0, 2'd0);
    send_item(ACT_POLL,   16'h5555, 8'hFF, 1'b1, 3'd7, 2'd3);
    send_item(ACT_READ,   16'hFFFF, 8'hFF, 1'b1, 3'd3, 2'd3);
    send_item(ACT_POLL,   16'hAAAA, 8'h0F, 1'b0, 3'd0, 2'd0);
    send_item(ACT_POLL,   16'hAAAA, 8'h00, 1'b1, 3'd0, 2'd0);
    send_item(ACT_POLL,   16'h0000, 8'hF0, 1'b1, 3'd0, 2'd0);
    send_item(ACT_POLL,   16'hFF00, 8'hFF, 1'b1, 3'd0, 2'd0);
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0, 3'd1, 2'd1);
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0, 3'd2, 2'd2);
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0, 3'd4, 2'd3);
    send_item(ACT_READ,   16'hFFFF, 8'hFF, 1'b1, 3'd7, 2'd3);
    send_item(ACT_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 3'd7, 2'd3);
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0, 3'd0, 2'd0);
    send_item(ACT_CLEAR,  16'hFFFF, 8'hFF, 1'b1, 3'd7, 2'd3);
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0, 3'd0, 2'd0);
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0, 3'd3, 2'd3);
    send_item(ACT_POLL,   16'h00FF, 8'h00, 1'b0, 3'd0, 2'd0);
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0, 3'd2, 2'd0);
    send_item(ACT_POLL,   16'h00FF, 8'h00, 1'b0, 3'd0, 2'd0);
    wait_drained();

    // Random runs: sticky direction and bank per run so counters saturate
    while (sent < ITEM_TARGET) begin
      run_len = $urandom_range(60, 200);
      step_pct = $urandom_range(30, 95);
      foreach (run_dir[i]) run_dir[i] = turn_t'($urandom_range(0, 2));
      run_btn = 8'($urandom);
      run_shift = 1'($urandom);
      case ($urandom_range(0, 2))
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 10; stall_pct = 15; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
      if ($urandom_range(0, 4) == 0)
        send_item(ACT_CLEAR, 16'($urandom), 8'($urandom), 1'($urandom),
                  3'($urandom), 2'($urandom));
      for (int k = 0; k < run_len && sent < ITEM_TARGET; k++) begin
        if (sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
        if (!paused && sent >= ITEM_TARGET / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        // occasional change of held buttons mid-run
        if ($urandom_range(0, 19) == 0) begin
          run_btn = 8'($urandom);
          run_shift = 1'($urandom);
        end
        pick = $urandom_range(0, 999);
        if (pick < 700)
          send_item(ACT_POLL, stepped_bits(), run_btn, run_shift,
                    3'($urandom), 2'($urandom));
        else if (pick < 740)
          send_item(ACT_POLL, 16'($urandom), 8'($urandom), 1'($urandom),
                    3'($urandom), 2'($urandom));
        else if (pick < 965)
          send_item(ACT_READ, 16'($urandom), 8'($urandom), 1'($urandom),
                    3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
        else if (pick < 995)
          send_item(ACT_UNUSED, 16'($urandom), 8'($urandom), 1'($urandom),
                    3'($urandom), 2'($urandom));
        else
          send_item(ACT_CLEAR, 16'($urandom), 8'($urandom), 1'($urandom),
                    3'($urandom), 2'($urandom));
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    board.close_out();
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
